@@ rtl/lduf_pkg.sv @@
// Shared types, constants and CRC helpers for the LED driver frame encoder.
package lduf_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'h79;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam int unsigned FRAME_BYTES = 5;
	localparam int unsigned CNT_W       = $clog2(FRAME_BYTES);

	// Index of the final byte for each frame type.
	localparam logic [CNT_W-1:0] READ_LAST_IDX  = CNT_W'(3);
	localparam logic [CNT_W-1:0] WRITE_LAST_IDX = CNT_W'(4);

	// x^k mod (x^3 + x + 1) repeats with period 7; entry j holds x^j.
	localparam logic [6:0][2:0] CRC_POW_TBL = {3'd5, 3'd7, 3'd6, 3'd3, 3'd4, 3'd2, 3'd1};

	typedef struct packed {
		logic        command;
		logic        broadcast;
		logic [5:0]  node_id;
		logic [7:0]  register_address;
		logic [12:0] write_value;
	} cmd_t;

	typedef struct packed {
		logic [FRAME_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]            last_idx;
	} frame_t;

	function automatic logic [7:0] reverse8(input logic [7:0] v);
		logic [7:0] r;
		for (int k = 0; k < 8; k++) begin
			r[7-k] = v[k];
		end
		return r;
	endfunction

	// Remainder modulo x^3 + x + 1 of a word whose low three bits count as zero.
	// Each set bit contributes its own power residue, so this is a flat XOR tree.
	function automatic logic [2:0] crc3(input logic [31:0] word);
		logic [2:0] r;
		r = 3'd0;
		for (int k = 3; k < 32; k++) begin
			if (word[k]) begin
				r = r ^ CRC_POW_TBL[k % 7];
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/led_driver_uart_frame_encoder_unit.sv @@
// Top level of the LED driver serial command frame encoder.
// With the output idle, an accepted command is held in the input register and then
// loaded into the output register, which then offers the sync byte.
// Throughput: one frame byte per cycle while byte_stall is low; a write frame has 5 bytes,
// a read frame 4, shifted out by the single frame-wide output register.
// The input register accepts the next command while the current frame drains.
// Reset (arst_n low) empties both the input and the output stages at once.
module led_driver_uart_frame_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic        command,
	input  logic        broadcast,
	input  logic [5:0]  node_id,
	input  logic [7:0]  register_address,
	input  logic [12:0] write_value,
	output logic        byte_valid,
	input  logic        byte_stall,
	output logic [7:0]  frame_byte,
	output logic        last_byte
);
	import lduf_pkg::*;

	cmd_t   cmd_s1;
	logic   valid_s1;
	frame_t frame;
	logic   load_ready;
	logic   accept;

	assign cmd_stall = valid_s1 && !load_ready;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= '{command: command, broadcast: broadcast, node_id: node_id,
				register_address: register_address, write_value: write_value};
		end
	end

	lduf_frame_build u_build (
		.cmd   (cmd_s1),
		.frame (frame)
	);

	lduf_byte_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_frame (frame),
		.load_ready (load_ready),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

@@ rtl/lduf_frame_build.sv @@
// Combinational frame builder: turns one registered command into its frame bytes.
module lduf_frame_build (
	input  lduf_pkg::cmd_t   cmd,
	output lduf_pkg::frame_t frame
);
	import lduf_pkg::*;

	logic [7:0]  id_byte;
	logic [4:0]  data_hi;
	logic [31:0] crc_word;
	logic [2:0]  crc;

	always_comb begin
		data_hi = cmd.write_value[12:8];
		if (cmd.command == CMD_WRITE) begin
			id_byte  = {cmd.broadcast, cmd.node_id, 1'b0};
			crc_word = {reverse8(id_byte), reverse8(cmd.register_address),
				reverse8(cmd.write_value[7:0]), reverse8({3'b000, data_hi})};
		end else begin
			id_byte  = {1'b0, cmd.node_id, 1'b1};
			crc_word = {8'h00, reverse8(id_byte), reverse8(cmd.register_address), 8'h00};
		end
		crc = crc3(crc_word);
	end

	always_comb begin
		frame.bytes[0] = SYNC_BYTE;
		frame.bytes[1] = id_byte;
		frame.bytes[2] = cmd.register_address;
		if (cmd.command == CMD_WRITE) begin
			frame.bytes[3] = cmd.write_value[7:0];
			frame.bytes[4] = {crc, data_hi};
			frame.last_idx = WRITE_LAST_IDX;
		end else begin
			frame.bytes[3] = {crc, 5'b00000};
			frame.bytes[4] = 8'h00;
			frame.last_idx = READ_LAST_IDX;
		end
	end

endmodule

@@ rtl/lduf_byte_serializer.sv @@
// Result register that holds one frame and shifts its bytes out one transaction at a time.
module lduf_byte_serializer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load_valid,
	input  lduf_pkg::frame_t load_frame,
	output logic             load_ready,
	output logic             byte_valid,
	input  logic             byte_stall,
	output logic [7:0]       frame_byte,
	output logic             last_byte
);
	import lduf_pkg::*;

	logic [FRAME_BYTES-1:0][7:0] shift_q;
	logic [CNT_W-1:0]            remain_q;
	logic                        valid_q;
	logic                        take;
	logic                        load;

	assign take       = valid_q && !byte_stall;
	assign load_ready = !valid_q || (take && remain_q == '0);
	assign load       = load_valid && load_ready;

	assign byte_valid = valid_q;
	assign frame_byte = shift_q[0];
	assign last_byte  = (remain_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			remain_q <= '0;
		end else if (load) begin
			valid_q  <= 1'b1;
			remain_q <= load_frame.last_idx;
		end else if (take) begin
			if (remain_q == '0) begin
				valid_q <= 1'b0;
			end else begin
				remain_q <= remain_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= load_frame.bytes;
		end else if (take) begin
			shift_q <= {8'h00, shift_q[FRAME_BYTES-1:1]};
		end
	end

	a_remain_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> remain_q <= WRITE_LAST_IDX)
		else $error("byte count beyond frame length");

	a_load_sync: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q && shift_q[0] == SYNC_BYTE)
		else $error("frame does not open with the sync byte");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(take && remain_q != '0 && !load) |=> valid_q && remain_q == $past(remain_q) - CNT_W'(1))
		else $error("byte count did not step after a transaction");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(take && remain_q == '0 && !load_valid) |=> !valid_q)
		else $error("output still valid after the final byte");

endmodule
